// ----- hdl/mia_pkg.sv -----
// Shared types and constants of the adjugate matrix inverse block.
package mia_pkg;

	// Width of one arithmetic limb and of the raw quotient kept by the divider.
	localparam int LIMB_W = 32;
	localparam int QUO_W  = 33;

	// Byte address of the dimension register.
	localparam logic [2:0] ADDR_DIMENSION = 3'd0;

	// Operations of the limb-serial multiply-accumulate unit.
	typedef enum logic [2:0] {
		MAC_IDLE,
		MAC_PROD_ONE,
		MAC_ACC_CLR,
		MAC_MUL,
		MAC_ADD
	} mac_op_t;

	typedef struct packed {
		mac_op_t op;
		logic    first;
		logic    sub;
	} mac_cmd_t;

	// Control of the permutation generator.
	typedef struct packed {
		logic clear;
		logic step;
	} perm_ctl_t;

	// Result of the serial divider.
	typedef struct packed {
		logic               done;
		logic               ovf;
		logic [QUO_W-1:0]   quo;
	} div_res_t;

endpackage

// ----- hdl/mia_perm.sv -----
// Permutation generator: Lehmer code counter with registered column selection.
module mia_perm import mia_pkg::*; #(
	parameter int MAX_DIM = 4,
	localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
	localparam int DW = $clog2(MAX_DIM + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  perm_ctl_t                    ctl,
	input  logic [DW-1:0]                dim,
	output logic [MAX_DIM-1:0][IW-1:0]   cols,
	output logic                         parity,
	output logic                         last_perm
);

	logic [MAX_DIM-1:0][IW-1:0] digit_q;
	logic [MAX_DIM-1:0][IW-1:0] digit_nxt;
	logic [MAX_DIM-1:0][IW-1:0] pick;
	logic [MAX_DIM-1:0]         at_max;
	logic [MAX_DIM-1:0]         used;
	logic [IW-1:0]              skip;
	logic                       found;
	logic                       carry;

	// A digit is at its top value when it equals dim-1-k; unused digits count as full.
	always_comb begin
		for (int k = 0; k < MAX_DIM; k++) begin
			at_max[k] = (32'(k) >= 32'(dim)) ||
				((32'(digit_q[k]) + 32'(k) + 32'd1) == 32'(dim));
		end
	end

	assign last_perm = &at_max;

	// The inversion count equals the digit sum, so its parity is the sign.
	always_comb begin
		parity = 1'b0;
		for (int k = 0; k < MAX_DIM; k++) begin
			parity = parity ^ digit_q[k][0];
		end
	end

	// Mixed-radix increment, last digit least significant.
	always_comb begin
		carry = 1'b1;
		for (int k = MAX_DIM - 1; k >= 0; k--) begin
			digit_nxt[k] = digit_q[k];
			if (carry) begin
				if (at_max[k]) begin
					digit_nxt[k] = '0;
				end else begin
					digit_nxt[k] = digit_q[k] + IW'(1);
					carry = 1'b0;
				end
			end
		end
	end

	// Each digit picks the n-th column not yet taken.
	always_comb begin
		used = '0;
		skip = '0;
		found = 1'b0;
		for (int k = 0; k < MAX_DIM; k++) begin
			pick[k] = '0;
			skip = digit_q[k];
			found = 1'b0;
			for (int c = 0; c < MAX_DIM; c++) begin
				if (!used[c] && !found) begin
					if (skip == '0) begin
						pick[k] = IW'(c);
						used[c] = 1'b1;
						found = 1'b1;
					end else begin
						skip = skip - IW'(1);
					end
				end
			end
		end
	end

	// Digit counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctl.clear) begin
			digit_q <= '0;
		end else if (ctl.step) begin
			digit_q <= digit_nxt;
		end
	end

	// Column selection, registered from the digits and following them in the next cycle.
	always_ff @(posedge clk) begin
		cols <= pick;
	end

endmodule

// ----- hdl/mia_mac.sv -----
// Limb-serial multiply-accumulate unit built around one 32x32 multiplier.
module mia_mac import mia_pkg::*; #(
	parameter int AL = 5,
	localparam int ACC_W = LIMB_W * AL
) (
	input  logic               clk,
	input  mac_cmd_t           cmd,
	input  logic [LIMB_W-1:0]  factor,
	output logic [ACC_W-1:0]   acc
);

	logic [LIMB_W-1:0] prod_q [AL];
	logic [LIMB_W-1:0] acc_q [AL];
	logic [LIMB_W-1:0] mcarry_q;
	logic              acarry_q;
	logic [2*LIMB_W-1:0] mul;
	logic [LIMB_W:0]     sum;

	// One limb product with the running carry limb.
	assign mul = {{LIMB_W{1'b0}}, prod_q[0]} * {{LIMB_W{1'b0}}, factor} +
		{{LIMB_W{1'b0}}, (cmd.first ? {LIMB_W{1'b0}} : mcarry_q)};

	// One limb of the accumulate; subtraction adds the complement plus one.
	assign sum = {1'b0, acc_q[0]} + {1'b0, (cmd.sub ? ~prod_q[0] : prod_q[0])} +
		(LIMB_W + 1)'(cmd.first ? cmd.sub : acarry_q);

	always_comb begin
		for (int k = 0; k < AL; k++) begin
			acc[k*LIMB_W +: LIMB_W] = acc_q[k];
		end
	end

	// Limbs rotate through position zero, least significant first.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			MAC_IDLE: begin
			end
			MAC_PROD_ONE: begin
				for (int k = 0; k < AL; k++) begin
					prod_q[k] <= (k == 0) ? LIMB_W'(1) : '0;
				end
			end
			MAC_ACC_CLR: begin
				for (int k = 0; k < AL; k++) begin
					acc_q[k] <= '0;
				end
			end
			MAC_MUL: begin
				for (int k = 0; k < AL - 1; k++) begin
					prod_q[k] <= prod_q[k+1];
				end
				prod_q[AL-1] <= mul[LIMB_W-1:0];
				mcarry_q <= mul[2*LIMB_W-1:LIMB_W];
			end
			MAC_ADD: begin
				for (int k = 0; k < AL - 1; k++) begin
					prod_q[k] <= prod_q[k+1];
					acc_q[k] <= acc_q[k+1];
				end
				prod_q[AL-1] <= prod_q[0];
				acc_q[AL-1] <= sum[LIMB_W-1:0];
				acarry_q <= sum[LIMB_W];
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- hdl/mia_div.sv -----
// Restoring divider, one quotient bit per cycle, for the rounded cofactor ratio.
module mia_div import mia_pkg::*; #(
	parameter int ACC_W = 160,
	parameter int SHIFT = 33,
	localparam int NW = ACC_W + SHIFT + 1,
	localparam int RW = ACC_W + 2,
	localparam int CW = $clog2(NW + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ACC_W-1:0]  num_mag,
	input  logic [ACC_W-1:0]  den_mag,
	output div_res_t          res
);

	logic [NW-1:0]    n_q;
	logic [RW-1:0]    r_q;
	logic [ACC_W:0]   d_q;
	logic [QUO_W-1:0] q_q;
	logic             ovf_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [RW-1:0]    rs;
	logic [RW-1:0]    dd;
	logic             qbit;

	assign rs = {r_q[RW-2:0], n_q[NW-1]};
	assign dd = RW'(d_q);
	assign qbit = (rs >= dd);

	assign res.done = done_q;
	assign res.ovf  = ovf_q;
	assign res.quo  = q_q;

	// Sequencing of the bit steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Numerator is the magnitude scaled by two to the shift plus the divisor half.
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= (NW'(num_mag) << SHIFT) + NW'(den_mag);
			d_q <= {den_mag, 1'b0};
			r_q <= '0;
			q_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			n_q <= {n_q[NW-2:0], 1'b0};
			r_q <= qbit ? (rs - dd) : rs;
			q_q <= {q_q[QUO_W-2:0], qbit};
			ovf_q <= ovf_q | q_q[QUO_W-1];
		end
	end

endmodule

// ----- hdl/matrix_inverse_adjugate.sv -----
// Top level of the adjugate matrix inverse: loader, sequencer, store and output register.
//
// The block loads an n x n matrix (n = dimension, 1..MAX_DIM), one signed Q16.16 beat per
// cycle in row-major order, then stops taking beats until all n*n inverse beats are in the
// output register. The determinant and each cofactor are exact sums over the n!
// permutations, and every product runs through one shared 32x32 multiplier one limb
// per cycle, with AL = MAX_DIM+1 limbs; each cofactor is then divided by the
// determinant in the one-bit-per-cycle divider. A singular matrix skips the cofactors
// and emits n*n zero beats.
module matrix_inverse_adjugate import mia_pkg::*; #(
	parameter int MAX_DIM = 4,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] element,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] inverse_value,
	output logic               singular,
	output logic               saturated,
	output logic               last
);

	localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DW    = $clog2(MAX_DIM + 1);
	localparam int CELLS = MAX_DIM * MAX_DIM;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int AL    = MAX_DIM + 1;
	localparam int LCW   = $clog2(AL);
	localparam int ACC_W = LIMB_W * AL;

	typedef enum logic [3:0] {
		S_LOAD,
		S_START,
		S_PSET,
		S_FREAD,
		S_FMUL,
		S_ADD,
		S_DONE,
		S_DIVGO,
		S_DIVW,
		S_EMIT
	} state_t;

	state_t        state_q;
	logic [2:0]    dim_raw_q;
	logic [DW-1:0] act_q;
	logic [IW-1:0] row_q;
	logic [IW-1:0] col_q;
	logic [IW-1:0] fk_q;
	logic [IW-1:0] oi_q;
	logic [IW-1:0] oj_q;
	logic [IW-1:0] top_idx;
	logic [LCW-1:0] lc_q;
	logic          det_phase_q;
	logic          det_zero_q;
	logic          det_neg_q;
	logic          cof_neg_q;
	logic          sgn_q;
	logic          unit_q;
	logic          uval_q;
	logic [ACC_W-1:0] dmag_q;
	logic [ACC_W-1:0] cof_mag_q;
	logic [31:0]   rd_q;
	logic [31:0]   mem_q [CELLS];
	logic          out_valid_q;
	logic [31:0]   out_value_q;
	logic          out_sing_q;
	logic          out_sat_q;
	logic          out_last_q;

	logic          cfg_wr;
	logic          in_take;
	logic          emit_load;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [31:0]   factor;
	logic          fneg;
	logic [ACC_W-1:0] acc;
	logic [ACC_W-1:0] acc_mag;
	logic          lc_end;
	logic          fk_end;
	logic          res_sat;
	logic [31:0]   res_value;
	mac_cmd_t      mac_cmd;
	perm_ctl_t     perm_ctl;
	div_res_t      div_res;
	logic          div_start;
	logic [MAX_DIM-1:0][IW-1:0] cols;
	logic          parity;
	logic          last_perm;

	// Register port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && ((paddr & 3'b100) == ADDR_DIMENSION);
	assign prdata = ((paddr & 3'b100) == ADDR_DIMENSION) ? {29'd0, dim_raw_q} : '0;

	// Handshakes.
	assign in_stall  = (state_q != S_LOAD);
	assign in_take   = in_valid && !in_stall;
	assign emit_load = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign inverse_value = out_value_q;
	assign singular  = out_sing_q;
	assign saturated = out_sat_q;
	assign last      = out_last_q;

	// Store addressing and limb/factor bookkeeping.
	assign top_idx = IW'(act_q - DW'(1));
	assign waddr  = AW'(row_q) * AW'(MAX_DIM) + AW'(col_q);
	assign raddr  = AW'(fk_q) * AW'(MAX_DIM) + AW'(cols[fk_q]);
	assign lc_end = (lc_q == LCW'(AL - 1));
	assign fk_end = (fk_q == top_idx);

	// Factor: a stored element, or the unit row that turns a determinant into a cofactor.
	assign fneg   = !unit_q && rd_q[31];
	assign factor = unit_q ? {31'd0, uval_q} : (fneg ? (~rd_q + 32'd1) : rd_q);
	assign acc_mag = acc[ACC_W-1] ? (~acc + ACC_W'(1)) : acc;

	// Rounded ratio saturated to the 32-bit range.
	always_comb begin
		if (cof_neg_q) begin
			res_sat = div_res.ovf || (div_res.quo > 33'h0_8000_0000);
			res_value = res_sat ? 32'h8000_0000 : (~div_res.quo[31:0] + 32'd1);
		end else begin
			res_sat = div_res.ovf || div_res.quo[32] || div_res.quo[31];
			res_value = res_sat ? 32'h7FFF_FFFF : div_res.quo[31:0];
		end
	end

	// Commands to the shared units.
	always_comb begin
		mac_cmd = '{op: MAC_IDLE, first: 1'b0, sub: 1'b0};
		perm_ctl = '{clear: 1'b0, step: 1'b0};
		div_start = 1'b0;
		unique case (state_q)
			S_START: begin
				mac_cmd.op = MAC_ACC_CLR;
				perm_ctl.clear = 1'b1;
			end
			S_PSET: mac_cmd.op = MAC_PROD_ONE;
			S_FMUL: begin
				mac_cmd.op = MAC_MUL;
				mac_cmd.first = (lc_q == '0);
			end
			S_ADD: begin
				mac_cmd.op = MAC_ADD;
				mac_cmd.first = (lc_q == '0);
				mac_cmd.sub = sgn_q;
				perm_ctl.step = lc_end && !last_perm;
			end
			S_DIVGO: div_start = 1'b1;
			default: begin
			end
		endcase
	end

	// Matrix store, one write and one registered read port.
	always_ff @(posedge clk) begin
		if (in_take) begin
			mem_q[waddr] <= element;
		end
		if (state_q == S_FREAD) begin
			rd_q <= mem_q[raddr];
		end
	end

	// Sequencer with the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			dim_raw_q <= 3'(MAX_DIM);
			act_q <= DW'(MAX_DIM);
			row_q <= '0;
			col_q <= '0;
			fk_q <= '0;
			oi_q <= '0;
			oj_q <= '0;
			lc_q <= '0;
			det_phase_q <= 1'b1;
			det_zero_q <= 1'b0;
			det_neg_q <= 1'b0;
			cof_neg_q <= 1'b0;
			sgn_q <= 1'b0;
			unit_q <= 1'b0;
			uval_q <= 1'b0;
			dmag_q <= '0;
			cof_mag_q <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_sing_q <= 1'b0;
			out_sat_q <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !emit_load) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				dim_raw_q <= pwdata[2:0];
				if (pwdata[2:0] == 3'd0) begin
					act_q <= DW'(1);
				end else if (32'(pwdata[2:0]) > 32'(MAX_DIM)) begin
					act_q <= DW'(MAX_DIM);
				end else begin
					act_q <= DW'(pwdata[2:0]);
				end
				row_q <= '0;
				col_q <= '0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (in_take) begin
						if (col_q == top_idx) begin
							col_q <= '0;
							if (row_q == top_idx) begin
								row_q <= '0;
								det_phase_q <= 1'b1;
								state_q <= S_START;
							end else begin
								row_q <= row_q + IW'(1);
							end
						end else begin
							col_q <= col_q + IW'(1);
						end
					end
				end
				S_START: state_q <= S_PSET;
				S_PSET: begin
					sgn_q <= parity;
					fk_q <= '0;
					state_q <= S_FREAD;
				end
				S_FREAD: begin
					unit_q <= !det_phase_q && (fk_q == oj_q);
					uval_q <= (cols[fk_q] == oi_q);
					lc_q <= '0;
					state_q <= S_FMUL;
				end
				S_FMUL: begin
					if (lc_q == '0) begin
						sgn_q <= sgn_q ^ fneg;
					end
					if (lc_end) begin
						lc_q <= '0;
						if (fk_end) begin
							fk_q <= '0;
							state_q <= S_ADD;
						end else begin
							fk_q <= fk_q + IW'(1);
							state_q <= S_FREAD;
						end
					end else begin
						lc_q <= lc_q + LCW'(1);
					end
				end
				S_ADD: begin
					if (lc_end) begin
						lc_q <= '0;
						state_q <= last_perm ? S_DONE : S_PSET;
					end else begin
						lc_q <= lc_q + LCW'(1);
					end
				end
				S_DONE: begin
					if (det_phase_q) begin
						det_phase_q <= 1'b0;
						det_neg_q <= acc[ACC_W-1];
						det_zero_q <= (acc == '0);
						dmag_q <= acc_mag;
						oi_q <= '0;
						oj_q <= '0;
						state_q <= (acc == '0) ? S_EMIT : S_START;
					end else begin
						cof_neg_q <= acc[ACC_W-1] ^ det_neg_q;
						cof_mag_q <= acc_mag;
						state_q <= S_DIVGO;
					end
				end
				S_DIVGO: state_q <= S_DIVW;
				S_DIVW: begin
					if (div_res.done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_load) begin
						out_valid_q <= 1'b1;
						out_value_q <= det_zero_q ? '0 : res_value;
						out_sing_q <= det_zero_q;
						out_sat_q <= !det_zero_q && res_sat;
						out_last_q <= (oi_q == top_idx) && (oj_q == top_idx);
						if (oj_q == top_idx) begin
							oj_q <= '0;
							if (oi_q == top_idx) begin
								oi_q <= '0;
								det_phase_q <= 1'b1;
								state_q <= S_LOAD;
							end else begin
								oi_q <= oi_q + IW'(1);
								state_q <= det_zero_q ? S_EMIT : S_START;
							end
						end else begin
							oj_q <= oj_q + IW'(1);
							state_q <= det_zero_q ? S_EMIT : S_START;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	mia_perm #(.MAX_DIM(MAX_DIM)) u_perm (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (perm_ctl),
		.dim       (act_q),
		.cols      (cols),
		.parity    (parity),
		.last_perm (last_perm)
	);

	mia_mac #(.AL(AL)) u_mac (
		.clk    (clk),
		.cmd    (mac_cmd),
		.factor (factor),
		.acc    (acc)
	);

	mia_div #(.ACC_W(ACC_W), .SHIFT(2 * FRAC_BITS + 1)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num_mag (cof_mag_q),
		.den_mag (dmag_q),
		.res     (div_res)
	);

`ifndef SYNTHESIS
	// A singular beat carries a zero value and no clip flag.
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> inverse_value == 32'sd0 && !saturated)
		else $error("singular beat with nonzero value or clip flag");

	// A clipped beat sits at one end of the 32-bit range.
	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
		inverse_value == 32'sh7FFF_FFFF || inverse_value == 32'sh8000_0000)
		else $error("clipped beat not at a range limit");

	// The dimension in use always lies within the supported range.
	a_dim_range: assert property (@(posedge clk) disable iff (!arst_n)
		act_q != '0 && 32'(act_q) <= 32'(MAX_DIM))
		else $error("active dimension out of range");

	// The divider finishes only while the sequencer waits for it.
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == S_DIVW)
		else $error("divider result arrived outside its wait state");
`endif

endmodule

// ----- bench/matrix_inverse_adjugate_test.sv -----
// Self-checking testbench for the adjugate matrix inverse block.
module matrix_inverse_adjugate_test;
	import mia_pkg::*;

	localparam int MAXD = 4;
	localparam int FRAC = 16;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE = 64;
	localparam int N_ROWS = 24;

	typedef logic signed [255:0] wide_t;

	// One expected beat of the inverse matrix.
	typedef struct {
		logic [31:0] value;
		logic        sing;
		logic        sat;
		logic        last;
	} inv_beat_t;

	// One row of the directed plan: a register write or an element beat.
	typedef enum logic {ROW_CFG, ROW_ELEM} row_kind_t;
	typedef struct {
		row_kind_t   kind;
		logic [31:0] data;
		bit          typed;
		logic [31:0] value;
		bit          sing;
		bit          sat;
	} plan_row_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] element;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] inverse_value;
	logic               singular;
	logic               saturated;
	logic               last;

	matrix_inverse_adjugate dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .element(element),
		.out_valid(out_valid), .out_stall(out_stall),
		.inverse_value(inverse_value), .singular(singular),
		.saturated(saturated), .last(last)
	);

	// Predictor state: register copy, loaded matrix and load position.
	logic [2:0]         dim_reg;
	logic signed [31:0] mat [MAXD*MAXD];
	int unsigned        load_cnt;

	inv_beat_t   pending_beats[$];
	int          errors;
	int          items_sent;
	int          beats_checked;
	int          singular_seen;
	int          saturated_seen;
	int          matrices_done;
	int          sender_idle_pct;
	int          stall_pct;
	longint      cycles;
	plan_row_t   plan [N_ROWS];

	// Clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Cycle count and watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d beats still expected", $time,
				pending_beats.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver stall, redrawn every cycle.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic int unsigned used_dim();
		if (dim_reg == 3'd0)
			return 1;
		if (dim_reg > MAXD)
			return MAXD;
		return dim_reg;
	endfunction

	// Exact determinant of the submatrix kept by the row and column masks,
	// expanded along its first kept row.
	function automatic wide_t minor_det(int unsigned rows, int unsigned cols, int unsigned n);
		int unsigned r;
		wide_t       acc;
		wide_t       sub;
		wide_t       e;
		bit          minus;
		r = 0;
		while (r < n && !rows[r])
			r++;
		if (r >= n)
			return 1;
		acc = 0;
		minus = 0;
		for (int unsigned c = 0; c < n; c++) begin
			if (cols[c]) begin
				sub = minor_det(rows & ~(1 << r), cols & ~(1 << c), n);
				e = mat[r*MAXD + c];
				sub = sub * e;
				acc = minus ? acc - sub : acc + sub;
				minus = !minus;
			end
		end
		return acc;
	endfunction

	// Loads one element; on the last element of the matrix, works out the
	// whole inverse as rounded, saturated beats.
	function automatic void load_element(input logic [31:0] v, output inv_beat_t beats[$]);
		int unsigned n;
		int unsigned full;
		wide_t       det;
		wide_t       dmag;
		wide_t       cof;
		wide_t       q;
		wide_t       lim;
		bit          neg;
		inv_beat_t   b;
		beats = {};
		n = used_dim();
		if (load_cnt >= n*n)
			load_cnt = 0;
		mat[(load_cnt / n)*MAXD + load_cnt % n] = v;
		load_cnt++;
		if (load_cnt < n*n)
			return;
		load_cnt = 0;
		full = (1 << n) - 1;
		det = minor_det(full, full, n);
		dmag = (det < 0) ? -det : det;
		for (int unsigned i = 0; i < n; i++) begin
			for (int unsigned j = 0; j < n; j++) begin
				b.value = 0;
				b.sing = (det == 0);
				b.sat = 0;
				b.last = (i == n-1 && j == n-1);
				if (det != 0) begin
					cof = minor_det(full & ~(1 << j), full & ~(1 << i), n);
					neg = (cof < 0) ^ ((i + j) % 2 == 1) ^ (det < 0);
					if (cof < 0)
						cof = -cof;
					// Round half away from zero: (2*|c|*2^32 + |d|) / (2*|d|).
					q = ((cof <<< (2*FRAC + 1)) + dmag) / (dmag <<< 1);
					lim = neg ? (wide_t'(1) <<< 31) : (wide_t'(1) <<< 31) - 1;
					if (q > lim) begin
						b.sat = 1;
						b.value = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
					end else begin
						b.value = neg ? -q[31:0] : q[31:0];
					end
				end
				beats.push_back(b);
			end
		end
	endfunction

	// Writes the dimension register through the setup and access phases.
	task automatic write_dimension(input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_DIMENSION;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		dim_reg = v[2:0];
		load_cnt = 0;
	endtask

	// Sends one element beat; the expectation replaces the prediction when typed.
	task automatic send_element(input logic [31:0] v, input bit typed, input inv_beat_t want);
		inv_beat_t beats[$];
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		element <= v;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
		load_element(v, beats);
		if (typed && beats.size() != 0)
			pending_beats.push_back(want);
		else
			foreach (beats[k])
				pending_beats.push_back(beats[k]);
		if (beats.size() != 0)
			matrices_done++;
	endtask

	// Stops sending and waits until every expected beat has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Sends one random n x n matrix; some are made singular by a repeated row.
	task automatic send_random_matrix();
		int unsigned        n;
		logic signed [31:0] m [MAXD*MAXD];
		int unsigned        r;
		inv_beat_t          none;
		n = used_dim();
		none = '{0, 0, 0, 0};
		for (int k = 0; k < n*n; k++) begin
			r = $urandom_range(9);
			if (r < 6)
				m[k] = $signed($urandom_range(8 << FRAC)) - (4 << FRAC);
			else if (r < 8)
				m[k] = $urandom;
			else if (r == 8)
				m[k] = ($signed($urandom_range(6)) - 3) <<< FRAC;
			else
				case ($urandom_range(4))
					0: m[k] = 32'h8000_0000;
					1: m[k] = 32'h7FFF_FFFF;
					2: m[k] = 0;
					3: m[k] = 1;
					default: m[k] = -1;
				endcase
		end
		if (n > 1 && $urandom_range(5) == 0)
			for (int c = 0; c < n; c++)
				m[(n-1)*n + c] = m[c];
		for (int k = 0; k < n*n; k++)
			send_element(m[k], 0, none);
	endtask

	task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
		$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
		errors++;
	endtask

	// Result checker: each accepted beat against the oldest expectation.
	always @(posedge clk) begin : check_beats
		inv_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual %h", $time,
					inverse_value);
				errors++;
			end else begin
				want = pending_beats.pop_front();
				beats_checked++;
				if (singular)
					singular_seen++;
				if (saturated)
					saturated_seen++;
				if (inverse_value !== want.value)
					report("inverse_value", want.value, inverse_value);
				if (singular !== want.sing)
					report("singular", want.sing, singular);
				if (saturated !== want.sat)
					report("saturated", want.sat, saturated);
				if (last !== want.last)
					report("last", want.last, last);
			end
		end
	end

	// Stimulus sequence.
	initial begin : stimulus
		int          rnd_dims [9];
		int          rnd_mats [9];
		inv_beat_t   want;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		element = '0;
		out_stall = 1'b0;
		cycles = 0;
		errors = 0;
		items_sent = 0;
		beats_checked = 0;
		singular_seen = 0;
		saturated_seen = 0;
		matrices_done = 0;
		dim_reg = MAXD;
		load_cnt = 0;
		foreach (mat[k])
			mat[k] = 0;
		sender_idle_pct = 10;
		stall_pct = 72;

		// Directed plan: one by one extremes, dimension zero, a singular
		// pair, a write in the middle of a load and a full-range pair.
		plan[0]  = '{ROW_CFG,  32'd1,          0, 0,             0, 0};
		plan[1]  = '{ROW_ELEM, 32'h0001_0000,  1, 32'h0001_0000, 0, 0};
		plan[2]  = '{ROW_ELEM, 32'h0000_0000,  1, 32'h0000_0000, 1, 0};
		plan[3]  = '{ROW_ELEM, 32'h0000_0001,  1, 32'h7FFF_FFFF, 0, 1};
		plan[4]  = '{ROW_ELEM, 32'h8000_0000,  1, 32'hFFFF_FFFE, 0, 0};
		plan[5]  = '{ROW_ELEM, 32'h7FFF_FFFF,  1, 32'h0000_0002, 0, 0};
		plan[6]  = '{ROW_ELEM, 32'hFFFF_FFFF,  1, 32'h8000_0000, 0, 1};
		plan[7]  = '{ROW_CFG,  32'd0,          0, 0,             0, 0};
		plan[8]  = '{ROW_ELEM, 32'h0002_0000,  1, 32'h0000_8000, 0, 0};
		plan[9]  = '{ROW_CFG,  32'd2,          0, 0,             0, 0};
		plan[10] = '{ROW_ELEM, 32'h0001_0000,  0, 0,             0, 0};
		plan[11] = '{ROW_ELEM, 32'h0002_0000,  0, 0,             0, 0};
		plan[12] = '{ROW_ELEM, 32'h0002_0000,  0, 0,             0, 0};
		plan[13] = '{ROW_ELEM, 32'h0004_0000,  0, 0,             0, 0};
		plan[14] = '{ROW_CFG,  32'd3,          0, 0,             0, 0};
		plan[15] = '{ROW_ELEM, 32'h0003_8000,  0, 0,             0, 0};
		plan[16] = '{ROW_ELEM, 32'hFFFE_0000,  0, 0,             0, 0};
		plan[17] = '{ROW_ELEM, 32'h0000_4000,  0, 0,             0, 0};
		plan[18] = '{ROW_ELEM, 32'h1234_5678,  0, 0,             0, 0};
		plan[19] = '{ROW_CFG,  32'd2,          0, 0,             0, 0};
		plan[20] = '{ROW_ELEM, 32'h7FFF_FFFF,  0, 0,             0, 0};
		plan[21] = '{ROW_ELEM, 32'h8000_0000,  0, 0,             0, 0};
		plan[22] = '{ROW_ELEM, 32'h8000_0000,  0, 0,             0, 0};
		plan[23] = '{ROW_ELEM, 32'h7FFF_FFFF,  0, 0,             0, 0};

		// Random phases: register values, including out-of-range ones,
		// and the number of matrices at each.
		rnd_dims = '{1, 2, 3, 4, 2, 7, 3, 0, 1};
		rnd_mats = '{12, 8, 4, 2, 8, 2, 4, 12, 12};

		// Reset.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		foreach (plan[k]) begin
			if (plan[k].kind == ROW_CFG) begin
				// A write with beats still expected waits for them first.
				drain();
				write_dimension(plan[k].data);
			end else begin
				want = '{plan[k].value, plan[k].sing, plan[k].sat, 1'b1};
				send_element(plan[k].data, plan[k].typed, want);
			end
		end

		// Random part under the three idling patterns.
		for (int p = 0; p < 9; p++) begin
			if (p == 3) begin
				sender_idle_pct = 72;
				stall_pct = 10;
			end else if (p == 6) begin
				sender_idle_pct = 0;
				stall_pct = 0;
			end
			drain();
			write_dimension(rnd_dims[p]);
			for (int m = 0; m < rnd_mats[p]; m++)
				send_random_matrix();
		end
		drain();

		$display("Sent %0d element beats in %0d matrices of sizes one to four.",
			items_sent, matrices_done);
		$display("Checked %0d inverse beats, %0d singular and %0d saturated.",
			beats_checked, singular_seen, saturated_seen);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/mia_pkg.sv
hdl/mia_perm.sv
hdl/mia_mac.sv
hdl/mia_div.sv
hdl/matrix_inverse_adjugate.sv
bench/matrix_inverse_adjugate_test.sv
